// ===== rtl/core/pgf_pkg.sv =====
// Package with widths, constants and request/result types of the pairwise gravity force core.
`default_nettype none
package pgf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 32;
  localparam int OUT_W     = 48;
  localparam int NUM_W     = 96;
  localparam int D2_W      = 65;
  localparam int DIST_W    = 33;
  localparam int SQ_STEPS  = 33;
  localparam int SQ_REM_W  = 34;

  localparam logic [63:0] FLOOR_RAW = ((64'd1 << (2 * FRAC_BITS)) + 64'd50) / 64'd100;
  localparam int FLOOR_LOG = $clog2(FLOOR_RAW + 64'd1) - 1;
  localparam int MAG_W     = NUM_W - FLOOR_LOG;
  localparam int MAG_CH    = (MAG_W + 31) / 32;
  localparam int PROD_W    = MAG_W + 32;

  localparam logic [IN_W-1:0]  G_RESET = IN_W'(64'd1 << FRAC_BITS);
  localparam logic [OUT_W-1:0] POS_LIM = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam logic [OUT_W-1:0] NEG_LIM = {1'b1, {(OUT_W - 1){1'b0}}};

  typedef struct packed {
    logic signed [IN_W-1:0] this_pos_x;
    logic signed [IN_W-1:0] this_pos_y;
    logic [IN_W-1:0]        this_mass;
    logic [IN_W-1:0]        this_radius;
    logic signed [IN_W-1:0] other_pos_x;
    logic signed [IN_W-1:0] other_pos_y;
    logic [IN_W-1:0]        other_mass;
    logic [IN_W-1:0]        other_radius;
  } pgf_req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] force_x;
    logic signed [OUT_W-1:0] force_y;
    logic                    colliding;
    logic                    saturated;
  } pgf_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/pairwise_gravity_force_core.sv =====
// Pipelined pairwise 2D gravitational force and collision test, fixed point.
//
// Requests arrive on in_valid_i/in_ready_o with in_req_i, results leave on
// out_valid_o/out_ready_i with out_res_o, one result per request, in order.
// The gravitational constant is written on cfg_valid_i/cfg_ready_o with
// cfg_data_i; the port is always ready; write it only while the pipeline is empty.
// Throughput: one request per cycle while the receiver is ready. Pipeline depth is
// set mainly by the two bit-per-stage restoring dividers: the force
// magnitude divider (MAG_W stages, square root folded into its first 33
// stages) and the pair of component dividers (MAG_W stages).
// When the receiver stalls the whole pipeline holds and in_ready_o drops;
// nothing is lost or repeated. Reset empties the pipeline and loads the
// gravitational constant with 1.0.
`default_nettype none
module pairwise_gravity_force_core
  import pgf_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire pgf_req_t        in_req_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output pgf_res_t             out_res_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [IN_W-1:0] cfg_data_i
);

  typedef struct packed {
    logic [D2_W-1:0]       rem;
    logic [MAG_W-1:0]      quo;
    logic [MAG_W-1:0]      num_lo;
    logic [D2_W-1:0]       den;
    logic [SQ_REM_W-1:0]   srem;
    logic [DIST_W-1:0]     root;
    logic [2*SQ_STEPS-1:0] src;
    logic [IN_W-1:0]       adx;
    logic [IN_W-1:0]       ady;
    logic                  sx;
    logic                  sy;
    logic                  col;
  } dv_t;

  typedef struct packed {
    logic [DIST_W-1:0] remx;
    logic [DIST_W-1:0] remy;
    logic [MAG_W-1:0]  qx;
    logic [MAG_W-1:0]  qy;
    logic [MAG_W-1:0]  px;
    logic [MAG_W-1:0]  py;
    logic [DIST_W-1:0] dvsr;
    logic              sx;
    logic              sy;
    logic              col;
  } cv_t;

  function automatic dv_t div_step(dv_t s, int bi);
    logic [D2_W:0] tr;
    logic [D2_W:0] df;
    dv_t n;
    n  = s;
    tr = {s.rem, s.num_lo[bi]};
    df = tr - {1'b0, s.den};
    if (tr >= {1'b0, s.den}) begin
      n.rem     = df[D2_W-1:0];
      n.quo[bi] = 1'b1;
    end else begin
      n.rem = tr[D2_W-1:0];
    end
    return n;
  endfunction

  function automatic dv_t sq_step(dv_t s, int sb);
    logic [SQ_REM_W+1:0] st;
    logic [SQ_REM_W+1:0] trial;
    logic [SQ_REM_W+1:0] sv;
    dv_t n;
    n     = s;
    st    = {s.srem, s.src[sb], s.src[sb-1]};
    trial = (SQ_REM_W + 2)'({s.root, 2'b01});
    sv    = st - trial;
    if (st >= trial) begin
      n.srem = sv[SQ_REM_W-1:0];
      n.root = {s.root[DIST_W-2:0], 1'b1};
    end else begin
      n.srem = st[SQ_REM_W-1:0];
      n.root = {s.root[DIST_W-2:0], 1'b0};
    end
    return n;
  endfunction

  function automatic cv_t cv_step(cv_t s, int bi);
    logic [DIST_W:0] tx;
    logic [DIST_W:0] ty;
    logic [DIST_W:0] dd;
    logic [DIST_W:0] fx;
    logic [DIST_W:0] fy;
    cv_t n;
    n  = s;
    dd = {1'b0, s.dvsr};
    tx = {s.remx, s.px[bi]};
    ty = {s.remy, s.py[bi]};
    fx = tx - dd;
    fy = ty - dd;
    if (tx >= dd) begin
      n.remx   = fx[DIST_W-1:0];
      n.qx[bi] = 1'b1;
    end else begin
      n.remx = tx[DIST_W-1:0];
    end
    if (ty >= dd) begin
      n.remy   = fy[DIST_W-1:0];
      n.qy[bi] = 1'b1;
    end else begin
      n.remy = ty[DIST_W-1:0];
    end
    return n;
  endfunction

  function automatic logic [OUT_W:0] clip(logic [MAG_W-1:0] q, logic neg, logic zero);
    logic [MAG_W-1:0] nq;
    logic [OUT_W-1:0] v;
    logic             s;
    nq = -q;
    v  = '0;
    s  = 1'b0;
    if (zero) begin
      v = '0;
    end else if (neg) begin
      if (q > MAG_W'(NEG_LIM)) begin
        s = 1'b1;
        v = NEG_LIM;
      end else begin
        v = nq[OUT_W-1:0];
      end
    end else begin
      if (q > MAG_W'(POS_LIM)) begin
        s = 1'b1;
        v = POS_LIM;
      end else begin
        v = q[OUT_W-1:0];
      end
    end
    return {s, v};
  endfunction

  logic en;
  logic [IN_W-1:0] gc_q;

  logic              a_v_q;
  logic [IN_W-1:0]   a_adx_q, a_ady_q, a_m1_q, a_m2_q;
  logic              a_sx_q, a_sy_q;
  logic [IN_W:0]     a_rsum_q;
  logic signed [IN_W:0] dx_c, dy_c;
  logic [IN_W:0]     ndx_c, ndy_c;

  logic              b_v_q;
  logic [63:0]       b_sqx_q, b_sqy_q, b_gm1_q;
  logic [65:0]       b_rs2_q;
  logic [IN_W-1:0]   b_m2_q, b_adx_q, b_ady_q;
  logic              b_sx_q, b_sy_q;

  logic              c_v_q;
  logic [D2_W-1:0]   c_d2_q;
  logic              c_col_q;
  logic [63:0]       c_plo_q, c_phi_q;
  logic [IN_W-1:0]   c_adx_q, c_ady_q;
  logic              c_sx_q, c_sy_q;
  logic [D2_W-1:0]   d2_c;

  logic [NUM_W-1:0]  num_c;
  logic [MAG_W:0]    dv_v_q;
  dv_t               dv_q [MAG_W+1];
  dv_t               dv_d [MAG_W+1];

  logic [MAG_CH*32-1:0] mag_ext;
  logic              p1_v_q;
  logic [63:0]       p1_ppx_q [MAG_CH];
  logic [63:0]       p1_ppy_q [MAG_CH];
  logic [DIST_W-1:0] p1_dist_q;
  logic              p1_sx_q, p1_sy_q, p1_col_q;

  logic [MAG_CH*32+31:0] accx_c, accy_c;
  logic              p2_v_q;
  logic [PROD_W-1:0] p2_px_q, p2_py_q;
  logic [DIST_W-1:0] p2_dist_q;
  logic              p2_sx_q, p2_sy_q, p2_col_q;

  logic [MAG_W:0]    cv_v_q;
  cv_t               cv_q [MAG_W+1];
  cv_t               cv_d [MAG_W+1];

  logic [OUT_W:0]    clx_c, cly_c;
  logic              zero_c;
  logic              out_valid_q;
  pgf_res_t          out_q;

  assign en          = ~out_valid_q | out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gc_q <= G_RESET;
    end else if (cfg_valid_i) begin
      gc_q <= cfg_data_i;
    end
  end

  always_comb begin
    dx_c  = $signed({in_req_i.other_pos_x[IN_W-1], in_req_i.other_pos_x})
          - $signed({in_req_i.this_pos_x[IN_W-1], in_req_i.this_pos_x});
    dy_c  = $signed({in_req_i.other_pos_y[IN_W-1], in_req_i.other_pos_y})
          - $signed({in_req_i.this_pos_y[IN_W-1], in_req_i.this_pos_y});
    ndx_c = -dx_c;
    ndy_c = -dy_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q       <= 1'b0;
      b_v_q       <= 1'b0;
      c_v_q       <= 1'b0;
      dv_v_q      <= '0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      cv_v_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      a_v_q       <= in_valid_i;
      b_v_q       <= a_v_q;
      c_v_q       <= b_v_q;
      dv_v_q      <= {dv_v_q[MAG_W-1:0], c_v_q};
      p1_v_q      <= dv_v_q[MAG_W];
      p2_v_q      <= p1_v_q;
      cv_v_q      <= {cv_v_q[MAG_W-1:0], p2_v_q};
      out_valid_q <= cv_v_q[MAG_W];
    end
  end

  // Front stages: differences, squares, products.
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_adx_q  <= dx_c[IN_W] ? ndx_c[IN_W-1:0] : dx_c[IN_W-1:0];
      a_ady_q  <= dy_c[IN_W] ? ndy_c[IN_W-1:0] : dy_c[IN_W-1:0];
      a_sx_q   <= dx_c[IN_W];
      a_sy_q   <= dy_c[IN_W];
      a_rsum_q <= {1'b0, in_req_i.this_radius} + {1'b0, in_req_i.other_radius};
      a_m1_q   <= in_req_i.this_mass;
      a_m2_q   <= in_req_i.other_mass;

      b_sqx_q  <= a_adx_q * a_adx_q;
      b_sqy_q  <= a_ady_q * a_ady_q;
      b_rs2_q  <= a_rsum_q * a_rsum_q;
      b_gm1_q  <= gc_q * a_m1_q;
      b_m2_q   <= a_m2_q;
      b_adx_q  <= a_adx_q;
      b_ady_q  <= a_ady_q;
      b_sx_q   <= a_sx_q;
      b_sy_q   <= a_sy_q;

      c_d2_q   <= d2_c;
      c_col_q  <= {1'b0, d2_c} < b_rs2_q;
      c_plo_q  <= b_gm1_q[31:0] * b_m2_q;
      c_phi_q  <= b_gm1_q[63:32] * b_m2_q;
      c_adx_q  <= b_adx_q;
      c_ady_q  <= b_ady_q;
      c_sx_q   <= b_sx_q;
      c_sy_q   <= b_sy_q;
    end
  end

  assign d2_c = {1'b0, b_sqx_q} + {1'b0, b_sqy_q};

  // Magnitude divider with the square root riding in its first stages.
  always_comb begin
    num_c            = {c_phi_q, 32'd0} + {32'd0, c_plo_q};
    dv_d[0].rem      = D2_W'(num_c[NUM_W-1:MAG_W]);
    dv_d[0].quo      = '0;
    dv_d[0].num_lo   = num_c[MAG_W-1:0];
    dv_d[0].den      = (c_d2_q < D2_W'(FLOOR_RAW)) ? D2_W'(FLOOR_RAW) : c_d2_q;
    dv_d[0].srem     = '0;
    dv_d[0].root     = '0;
    dv_d[0].src      = {1'b0, c_d2_q};
    dv_d[0].adx      = c_adx_q;
    dv_d[0].ady      = c_ady_q;
    dv_d[0].sx       = c_sx_q;
    dv_d[0].sy       = c_sy_q;
    dv_d[0].col      = c_col_q;
  end

  for (genvar k = 0; k < MAG_W; k++) begin : g_dv
    if (k < SQ_STEPS) begin : g_sq
      assign dv_d[k+1] = sq_step(div_step(dv_q[k], MAG_W - 1 - k), 2 * SQ_STEPS - 1 - 2 * k);
    end else begin : g_pass
      assign dv_d[k+1] = div_step(dv_q[k], MAG_W - 1 - k);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= MAG_W; k++) begin
        dv_q[k] <= dv_d[k];
      end
    end
  end

  // Partial products of magnitude and component deltas, then their sums.
  assign mag_ext = (MAG_CH * 32)'(dv_q[MAG_W].quo);

  always_comb begin
    accx_c = '0;
    accy_c = '0;
    for (int c = 0; c < MAG_CH; c++) begin
      accx_c = accx_c + ((MAG_CH * 32 + 32)'(p1_ppx_q[c]) << (32 * c));
      accy_c = accy_c + ((MAG_CH * 32 + 32)'(p1_ppy_q[c]) << (32 * c));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < MAG_CH; c++) begin
        p1_ppx_q[c] <= mag_ext[32*c +: 32] * dv_q[MAG_W].adx;
        p1_ppy_q[c] <= mag_ext[32*c +: 32] * dv_q[MAG_W].ady;
      end
      p1_dist_q <= dv_q[MAG_W].root;
      p1_sx_q   <= dv_q[MAG_W].sx;
      p1_sy_q   <= dv_q[MAG_W].sy;
      p1_col_q  <= dv_q[MAG_W].col;

      p2_px_q   <= accx_c[PROD_W-1:0];
      p2_py_q   <= accy_c[PROD_W-1:0];
      p2_dist_q <= p1_dist_q;
      p2_sx_q   <= p1_sx_q;
      p2_sy_q   <= p1_sy_q;
      p2_col_q  <= p1_col_q;
    end
  end

  // Component dividers by the distance.
  always_comb begin
    cv_d[0].remx = DIST_W'(p2_px_q[PROD_W-1:MAG_W]);
    cv_d[0].remy = DIST_W'(p2_py_q[PROD_W-1:MAG_W]);
    cv_d[0].qx   = '0;
    cv_d[0].qy   = '0;
    cv_d[0].px   = p2_px_q[MAG_W-1:0];
    cv_d[0].py   = p2_py_q[MAG_W-1:0];
    cv_d[0].dvsr = p2_dist_q;
    cv_d[0].sx   = p2_sx_q;
    cv_d[0].sy   = p2_sy_q;
    cv_d[0].col  = p2_col_q;
  end

  for (genvar k = 0; k < MAG_W; k++) begin : g_cv
    assign cv_d[k+1] = cv_step(cv_q[k], MAG_W - 1 - k);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= MAG_W; k++) begin
        cv_q[k] <= cv_d[k];
      end
    end
  end

  // Sign, clip, hold the result.
  always_comb begin
    zero_c = (cv_q[MAG_W].dvsr == '0);
    clx_c  = clip(cv_q[MAG_W].qx, cv_q[MAG_W].sx, zero_c);
    cly_c  = clip(cv_q[MAG_W].qy, cv_q[MAG_W].sy, zero_c);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.force_x   <= clx_c[OUT_W-1:0];
      out_q.force_y   <= cly_c[OUT_W-1:0];
      out_q.colliding <= cv_q[MAG_W].col;
      out_q.saturated <= clx_c[OUT_W] | cly_c[OUT_W];
    end
  end

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("request taken while result stalled");

  a_last_stage_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cv_v_q[MAG_W] && en) |=> out_valid_q)
    else $error("result lost at output stage");

  a_saturated_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.saturated) |->
      (out_q.force_x == POS_LIM || out_q.force_x == NEG_LIM ||
       out_q.force_y == POS_LIM || out_q.force_y == NEG_LIM))
    else $error("saturated flag without clipped force");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_pairwise_gravity_force_core.sv =====
// Testbench for pairwise_gravity_force_core: directed and random requests against a predictor.
`default_nettype none
module tb_pairwise_gravity_force_core
  import pgf_pkg::*;
();

  localparam logic [127:0] D2_FLOOR = 128'd42949673;
  localparam logic [127:0] POS_MAX = 128'h7FFF_FFFF_FFFF;
  localparam logic [127:0] NEG_MAX = 128'h8000_0000_0000;
  localparam int LATENCY = 160;
  localparam int STALL_LIMIT = 20000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  pgf_req_t in_req_i;
  logic out_valid_o;
  logic out_ready_i;
  pgf_res_t out_res_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [IN_W-1:0] cfg_data_i;

  pgf_res_t force_q[$];
  logic [31:0] grav_const;
  int errors;
  int n_sent;
  int n_checked;
  int n_sat;
  int n_coll;
  int stall_pct;
  int hold_left;
  int idle_cycles;

  pairwise_gravity_force_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_res_o(out_res_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [47:0] axis_force(input logic [127:0] mag,
                                             input logic signed [33:0] delta,
                                             input logic [127:0] root, inout bit sat);
    logic [127:0] ad;
    logic [127:0] c;
    ad = (delta < 0) ? 128'(-delta) : 128'(delta);
    if (root == 0) return 48'd0;
    c = (mag * ad) / root;
    if (delta < 0) begin
      if (c > NEG_MAX) begin
        sat = 1'b1;
        return NEG_MAX[47:0];
      end
      return 48'(-c);
    end
    if (c > POS_MAX) begin
      sat = 1'b1;
      return POS_MAX[47:0];
    end
    return c[47:0];
  endfunction

  function automatic pgf_res_t pair_force(input pgf_req_t r, input logic [31:0] g);
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic [127:0] adx;
    logic [127:0] ady;
    logic [127:0] d2;
    logic [127:0] rs2;
    logic [127:0] num;
    logic [127:0] mag;
    logic [127:0] root;
    logic [127:0] cand;
    logic [127:0] rsum;
    bit sat;
    pgf_res_t res;
    dx = $signed(r.other_pos_x) - $signed(r.this_pos_x);
    dy = $signed(r.other_pos_y) - $signed(r.this_pos_y);
    adx = (dx < 0) ? 128'(-dx) : 128'(dx);
    ady = (dy < 0) ? 128'(-dy) : 128'(dy);
    d2 = adx * adx + ady * ady;
    rsum = 128'(r.this_radius) + 128'(r.other_radius);
    rs2 = rsum * rsum;
    num = 128'(g) * 128'(r.this_mass) * 128'(r.other_mass);
    mag = num / ((d2 < D2_FLOOR) ? D2_FLOOR : d2);
    root = 0;
    for (int b = 34; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= d2) root = cand;
    end
    sat = 1'b0;
    res.force_x = axis_force(mag, dx, root, sat);
    res.force_y = axis_force(mag, dy, root, sat);
    res.colliding = (d2 < rs2);
    res.saturated = sat;
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) force_q.push_back(pair_force(in_req_i, grav_const));
  end

  always @(posedge clk_i) begin
    pgf_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_checked++;
      if (force_q.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        want = force_q.pop_front();
        if (want.colliding) n_coll++;
        if (want.saturated) n_sat++;
        if (out_res_o.force_x !== want.force_x) begin
          $error("force_x expected %h actual %h", want.force_x, out_res_o.force_x);
          errors++;
        end
        if (out_res_o.force_y !== want.force_y) begin
          $error("force_y expected %h actual %h", want.force_y, out_res_o.force_y);
          errors++;
        end
        if (out_res_o.colliding !== want.colliding) begin
          $error("colliding expected %b actual %b", want.colliding, out_res_o.colliding);
          errors++;
        end
        if (out_res_o.saturated !== want.saturated) begin
          $error("saturated expected %b actual %b", want.saturated, out_res_o.saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_req(input pgf_req_t r);
    in_valid_i <= 1'b1;
    in_req_i <= r;
    n_sent++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    pause_sender(1);
    wait (force_q.size() == 0);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_gravity(input logic [31:0] g);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= g;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    grav_const = g;
  endtask

  function automatic pgf_req_t make_pair(input pgf_req_t base, input logic signed [31:0] tx,
                                         input logic signed [31:0] ty,
                                         input logic signed [31:0] ox,
                                         input logic signed [31:0] oy);
    pgf_req_t r;
    r = base;
    r.this_pos_x = tx;
    r.this_pos_y = ty;
    r.other_pos_x = ox;
    r.other_pos_y = oy;
    return r;
  endfunction

  function automatic logic [31:0] rand_scalar();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0010_0000);
      2: return $urandom_range(0, 32'h0100_0000);
      default: return 32'hFFFF_FFFF - $urandom_range(0, 255);
    endcase
  endfunction

  function automatic pgf_req_t rand_req();
    pgf_req_t r;
    r.this_pos_x = $urandom();
    r.this_pos_y = $urandom();
    r.this_mass = rand_scalar();
    r.this_radius = rand_scalar();
    r.other_mass = rand_scalar();
    r.other_radius = rand_scalar();
    case ($urandom_range(0, 3))
      0: begin
        r.other_pos_x = $urandom();
        r.other_pos_y = $urandom();
      end
      1: begin
        r.other_pos_x = r.this_pos_x + $signed(32'($urandom_range(0, 32'h0004_0000))) - 32'sh2_0000;
        r.other_pos_y = r.this_pos_y + $signed(32'($urandom_range(0, 32'h0004_0000))) - 32'sh2_0000;
      end
      2: begin
        r.other_pos_x = r.this_pos_x + $signed(32'($urandom_range(0, 64))) - 32'sd32;
        r.other_pos_y = r.this_pos_y + $signed(32'($urandom_range(0, 64))) - 32'sd32;
      end
      default: begin
        r.other_pos_x = r.this_pos_x + $signed(32'($urandom_range(0, 32'h0800_0000)));
        r.other_pos_y = r.this_pos_y - $signed(32'($urandom_range(0, 32'h0800_0000)));
      end
    endcase
    return r;
  endfunction

  task automatic run_random(input int count, input int stall);
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      send_req(rand_req());
      if ($urandom_range(0, 9) == 0) pause_sender($urandom_range(1, 20));
    end
  endtask

  task automatic test_directed();
    pgf_req_t b;
    b.this_mass = 32'h0001_0000;
    b.other_mass = 32'h0001_0000;
    b.this_radius = 32'h0001_0000;
    b.other_radius = 32'h0001_0000;
    b.this_pos_x = 0;
    b.this_pos_y = 0;
    b.other_pos_x = 0;
    b.other_pos_y = 0;
    stall_pct = 0;
    send_req(make_pair(b, 0, 0, 32'sh1_0000, 0));
    send_req(make_pair(b, 0, 0, -32'sh1_0000, 32'sh3_0000));
    send_req(make_pair(b, 32'sh5_0000, 32'sh5_0000, 32'sh5_0000, 32'sh5_0000));
    b.this_radius = 0;
    b.other_radius = 0;
    send_req(make_pair(b, 32'sh5_0000, -32'sh5_0000, 32'sh5_0000, -32'sh5_0000));
    send_req(make_pair(b, 0, 0, 32'sd1, 0));
    send_req(make_pair(b, 0, 0, 0, -32'sd300));
    b.this_radius = 32'hFFFF_FFFF;
    b.other_radius = 32'hFFFF_FFFF;
    send_req(make_pair(b, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    send_req(make_pair(b, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000));
    b.this_mass = 32'hFFFF_FFFF;
    b.other_mass = 32'hFFFF_FFFF;
    send_req(make_pair(b, 0, 0, 32'sd7, -32'sd5));
    send_req(make_pair(b, 0, 0, -32'sd7, 32'sd5));
    send_req(make_pair(b, 32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0));
    send_req(make_pair(b, 0, 32'sh7FFF_FFFF, 0, 32'sh8000_0000));
    send_req(make_pair(b, 32'sd3, 32'sd3, 32'sd3, 32'sd3));
    b.this_mass = 0;
    send_req(make_pair(b, 0, 0, 32'sd100, 32'sd100));
    b.this_mass = 32'hFFFF_FFFF;
    b.other_mass = 0;
    b.this_radius = 0;
    send_req(make_pair(b, 0, 0, -32'sh10_0000, -32'sh10_0000));
    drain();
  endtask

  task automatic test_gravity_settings();
    logic [31:0] g_list[4];
    g_list[0] = 32'd0;
    g_list[1] = 32'hFFFF_FFFF;
    g_list[2] = 32'd1;
    g_list[3] = $urandom();
    foreach (g_list[k]) begin
      write_gravity(g_list[k]);
      run_random(100, 20);
    end
    write_gravity(32'h0001_0000);
  endtask

  task automatic test_backpressure();
    @(posedge clk_i);
    hold_left <= 400;
    for (int i = 0; i < 250; i++) send_req(rand_req());
    drain();
  endtask

  task automatic test_random_traffic();
    run_random(300, 0);
    run_random(300, 50);
    run_random(200, 85);
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    grav_const = 32'h0001_0000;
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_sat = 0;
    n_coll = 0;
    stall_pct = 0;
    hold_left = 0;
    idle_cycles = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic();
    test_backpressure();
    test_gravity_settings();
    drain();
    if (force_q.size() != 0) errors++;
    $display("covered %0d requests, %0d results checked (%0d saturated, %0d colliding)",
             n_sent, n_checked, n_sat, n_coll);
    $display("gravity settings zero, one lsb, max, random and 1.0; receiver hold-off of 400");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
